[rtl/lfdc_pkg.sv]
// ----------------------------------------------------------------------------
// lfdc_pkg
// Shared widths, codes, reset values, types and helpers of the line-follow
// drive controller.
// ----------------------------------------------------------------------------
package lfdc_pkg;

  localparam int WIDTH_W    = 14;
  localparam int GAIN_W     = 12;
  localparam int TICK_W     = 16;
  localparam int HOLD_W     = 4;
  localparam int MASK_W     = 8;
  localparam int OP_W       = 2;
  localparam int CMD_W      = 3;
  localparam int HEAD_W     = 3;
  localparam int WEIGHT_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = GAIN_W + 1 + WEIGHT_W;   // signed gain * weight
  localparam int SUM_W      = WIDTH_W + 3;             // signed base -/+ product

  // Event codes
  localparam logic [OP_W-1:0] OP_COMMAND = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CONTROL = 2'd2;
  localparam logic [OP_W-1:0] OP_TURN    = 2'd3;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FWD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_BACK  = 3'd4;

  // Heading codes
  localparam logic [HEAD_W-1:0] HEAD_STOP  = 3'd0;
  localparam logic [HEAD_W-1:0] HEAD_FWD   = 3'd1;
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 3'd2;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 3'd3;
  localparam logic [HEAD_W-1:0] HEAD_BACK  = 3'd4;

  // Wheel reverse codes: bit 0 left, bit 1 right
  localparam logic [1:0] REV_NONE  = 2'd0;
  localparam logic [1:0] REV_LEFT  = 2'd1;
  localparam logic [1:0] REV_RIGHT = 2'd2;
  localparam logic [1:0] REV_BOTH  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_TICKS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK       = 3'd6;

  // Configuration reset values
  localparam logic [WIDTH_W-1:0] RST_FULL_SPEED = 14'd9500;
  localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH  = 14'd10000;
  localparam logic [GAIN_W-1:0]  RST_LEFT_GAIN  = 12'd2250;
  localparam logic [GAIN_W-1:0]  RST_RIGHT_GAIN = 12'd2000;
  localparam logic [TICK_W-1:0]  RST_TURN_TICKS = 16'd100;
  localparam logic [HOLD_W-1:0]  RST_HOLDOFF    = 4'd10;
  localparam logic [MASK_W-1:0]  RST_MASK       = 8'h3C;

  // State reset values
  localparam logic [HOLD_W-1:0] RST_HOLD_COUNT = 4'd5;

  // Sensor patterns that set the line weight
  localparam logic [MASK_W-1:0] PAT_M3 = 8'h03;
  localparam logic [MASK_W-1:0] PAT_M2 = 8'h06;
  localparam logic [MASK_W-1:0] PAT_M1 = 8'h0C;
  localparam logic [MASK_W-1:0] PAT_Z0 = 8'h18;
  localparam logic [MASK_W-1:0] PAT_P1 = 8'h30;
  localparam logic [MASK_W-1:0] PAT_P2 = 8'h60;
  localparam logic [MASK_W-1:0] PAT_P3 = 8'hC0;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CMD_W-1:0]  command_code;
    logic [MASK_W-1:0] line_bits;
  } item_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] full_speed_width;
    logic [WIDTH_W-1:0] max_width;
    logic [GAIN_W-1:0]  left_gain;
    logic [GAIN_W-1:0]  right_gain;
    logic [TICK_W-1:0]  turn_ticks;
    logic [HOLD_W-1:0]  holdoff_samples;
    logic [MASK_W-1:0]  crossing_mask;
  } cfg_t;

  // Map a sensor byte to a line weight; unlisted patterns keep the old one
  function automatic logic signed [WEIGHT_W-1:0] weight_of(
    input logic [MASK_W-1:0]          bits,
    input logic signed [WEIGHT_W-1:0] hold
  );
    logic signed [WEIGHT_W-1:0] w;
    case (bits)
      PAT_M3:  w = -3'sd3;
      PAT_M2:  w = -3'sd2;
      PAT_M1:  w = -3'sd1;
      PAT_Z0:  w = 3'sd0;
      PAT_P1:  w = 3'sd1;
      PAT_P2:  w = 3'sd2;
      PAT_P3:  w = 3'sd3;
      default: w = hold;
    endcase
    return w;
  endfunction

  // Clamp to max first, then to zero
  function automatic logic [WIDTH_W-1:0] clamp_width(
    input logic signed [SUM_W-1:0] v,
    input logic [WIDTH_W-1:0]      max_w
  );
    logic [WIDTH_W-1:0] r;
    if (v >= $signed({3'b000, max_w})) begin
      r = max_w;
    end else if (v <= $signed({SUM_W{1'b0}})) begin
      r = '0;
    end else begin
      r = v[WIDTH_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/lfdc_if.sv]
// ----------------------------------------------------------------------------
// lfdc_in_if / lfdc_out_if
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface lfdc_in_if import lfdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CMD_W-1:0]  command_code;
  logic [MASK_W-1:0] line_bits;

  modport source  (output valid, output op, output command_code, output line_bits,
                   input ready);
  modport sink    (input valid, input op, input command_code, input line_bits,
                   output ready);
  modport monitor (input valid, input ready, input op, input command_code,
                   input line_bits);
endinterface

interface lfdc_out_if import lfdc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] left_width;
  logic [WIDTH_W-1:0] right_width;
  logic               left_back;
  logic               right_back;
  logic               move_done;
  logic [HEAD_W-1:0]  heading;

  modport source  (output valid, output left_width, output right_width,
                   output left_back, output right_back, output move_done,
                   output heading, input ready);
  modport sink    (input valid, input left_width, input right_width,
                   input left_back, input right_back, input move_done,
                   input heading, output ready);
  modport monitor (input valid, input ready, input left_width, input right_width,
                   input left_back, input right_back, input move_done,
                   input heading);
endinterface

[rtl/lfdc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// lfdc_cfg_regs
// Configuration register file, written by index, no read-back.
// ----------------------------------------------------------------------------
module lfdc_cfg_regs import lfdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FULL_SPEED: cfg_nxt.full_speed_width = cfg_data[WIDTH_W-1:0];
        CFG_MAX_WIDTH:  cfg_nxt.max_width        = cfg_data[WIDTH_W-1:0];
        CFG_LEFT_GAIN:  cfg_nxt.left_gain        = cfg_data[GAIN_W-1:0];
        CFG_RIGHT_GAIN: cfg_nxt.right_gain       = cfg_data[GAIN_W-1:0];
        CFG_TURN_TICKS: cfg_nxt.turn_ticks       = cfg_data[TICK_W-1:0];
        CFG_HOLDOFF:    cfg_nxt.holdoff_samples  = cfg_data[HOLD_W-1:0];
        CFG_MASK:       cfg_nxt.crossing_mask    = cfg_data[MASK_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_speed_width <= RST_FULL_SPEED;
      cfg_r.max_width        <= RST_MAX_WIDTH;
      cfg_r.left_gain        <= RST_LEFT_GAIN;
      cfg_r.right_gain       <= RST_RIGHT_GAIN;
      cfg_r.turn_ticks       <= RST_TURN_TICKS;
      cfg_r.holdoff_samples  <= RST_HOLDOFF;
      cfg_r.crossing_mask    <= RST_MASK;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/lfdc_in_reg.sv]
// ----------------------------------------------------------------------------
// lfdc_in_reg
// Input register: captures one event word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module lfdc_in_reg import lfdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  lfdc_in_if.sink  in_chan,
  input  logic     advance,
  output logic     item_valid,
  output item_t    item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  take;

  // Accept when empty or when the held word moves on this cycle
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.op           <= in_chan.op;
      item_r.command_code <= in_chan.command_code;
      item_r.line_bits    <= in_chan.line_bits;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[rtl/lfdc_core.sv]
// ----------------------------------------------------------------------------
// lfdc_core
// Drive state, single-pass event logic and the result register.
// ----------------------------------------------------------------------------
module lfdc_core import lfdc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       item_valid,
  input  item_t      item,
  output logic       advance,
  lfdc_out_if.source out_chan
);

  // Drive state
  logic [HEAD_W-1:0]          heading_r,  heading_nxt;
  logic signed [WEIGHT_W-1:0] weight_r,   weight_nxt;
  logic [HOLD_W-1:0]          hold_cnt_r, hold_cnt_nxt;
  logic [TICK_W-1:0]          turn_cnt_r, turn_cnt_nxt;
  logic [WIDTH_W-1:0]         ltgt_r,     ltgt_nxt;
  logic [WIDTH_W-1:0]         rtgt_r,     rtgt_nxt;
  logic [WIDTH_W-1:0]         lapp_r,     lapp_nxt;
  logic [WIDTH_W-1:0]         rapp_r,     rapp_nxt;
  logic [1:0]                 rev_r,      rev_nxt;
  logic                       done_nxt;

  // Result register
  logic out_valid_r;
  logic out_valid_nxt;
  logic out_done_r;

  logic                     straight;
  logic                     new_straight;
  logic signed [PROD_W-1:0] lprod;
  logic signed [PROD_W-1:0] rprod;
  logic signed [SUM_W-1:0]  lsum;
  logic signed [SUM_W-1:0]  rsum;

  // Move the held word when the result slot is free or being emptied
  assign advance = item_valid && (!out_valid_r || out_chan.ready);

  assign straight = (heading_r == HEAD_FWD) || (heading_r == HEAD_BACK);

  // Steering law on the current line weight
  always_comb begin
    lprod = $signed({1'b0, cfg.left_gain}) * weight_r;
    rprod = $signed({1'b0, cfg.right_gain}) * weight_r;
    lsum  = $signed({3'b000, cfg.full_speed_width}) - SUM_W'(lprod);
    rsum  = $signed({3'b000, cfg.full_speed_width}) + SUM_W'(rprod);
  end

  // Next state for one event
  always_comb begin
    heading_nxt  = heading_r;
    weight_nxt   = weight_r;
    hold_cnt_nxt = hold_cnt_r;
    turn_cnt_nxt = turn_cnt_r;
    ltgt_nxt     = ltgt_r;
    rtgt_nxt     = rtgt_r;
    lapp_nxt     = lapp_r;
    rapp_nxt     = rapp_r;
    rev_nxt      = rev_r;
    done_nxt     = 1'b0;
    new_straight = straight;

    case (item.op)
      OP_COMMAND: begin
        case (item.command_code)
          CMD_STOP: begin
            heading_nxt = HEAD_STOP;
          end
          CMD_FWD: begin
            heading_nxt = HEAD_FWD;
            rev_nxt     = REV_NONE;
          end
          CMD_RIGHT: begin
            heading_nxt = HEAD_RIGHT;
            rev_nxt     = REV_RIGHT;
          end
          CMD_LEFT: begin
            heading_nxt = HEAD_LEFT;
            rev_nxt     = REV_LEFT;
          end
          CMD_BACK: begin
            heading_nxt = HEAD_BACK;
            rev_nxt     = REV_BOTH;
          end
          default: begin
            heading_nxt = heading_r;
          end
        endcase
        // Stop clears the widths, drive loads full speed
        if (item.command_code == CMD_STOP) begin
          ltgt_nxt = '0;
          rtgt_nxt = '0;
          lapp_nxt = '0;
          rapp_nxt = '0;
        end else if (item.command_code == CMD_FWD || item.command_code == CMD_RIGHT ||
                     item.command_code == CMD_LEFT || item.command_code == CMD_BACK) begin
          ltgt_nxt = cfg.full_speed_width;
          rtgt_nxt = cfg.full_speed_width;
          lapp_nxt = cfg.full_speed_width;
          rapp_nxt = cfg.full_speed_width;
        end
        // Restart the crossing holdoff on straight travel
        new_straight = (heading_nxt == HEAD_FWD) || (heading_nxt == HEAD_BACK);
        if (item.command_code != CMD_STOP && new_straight) begin
          hold_cnt_nxt = '0;
        end
      end
      OP_SAMPLE: begin
        weight_nxt = weight_of(item.line_bits, weight_r);
        if (straight && hold_cnt_r != cfg.holdoff_samples) begin
          hold_cnt_nxt = hold_cnt_r + 1'b1;
        end else if (straight &&
                     (item.line_bits & cfg.crossing_mask) == cfg.crossing_mask) begin
          heading_nxt = HEAD_STOP;
          ltgt_nxt    = '0;
          rtgt_nxt    = '0;
          lapp_nxt    = '0;
          rapp_nxt    = '0;
          done_nxt    = 1'b1;
        end
      end
      OP_CONTROL: begin
        if ((ltgt_r != '0 || rtgt_r != '0) && straight) begin
          ltgt_nxt = clamp_width(lsum, cfg.max_width);
          rtgt_nxt = clamp_width(rsum, cfg.max_width);
          lapp_nxt = clamp_width(lsum, cfg.max_width);
          rapp_nxt = clamp_width(rsum, cfg.max_width);
        end
      end
      OP_TURN: begin
        if (heading_r == HEAD_LEFT || heading_r == HEAD_RIGHT) begin
          if (turn_cnt_r >= cfg.turn_ticks) begin
            lapp_nxt     = '0;
            rapp_nxt     = '0;
            heading_nxt  = HEAD_STOP;
            turn_cnt_nxt = '0;
            done_nxt     = 1'b1;
          end else begin
            turn_cnt_nxt = turn_cnt_r + 1'b1;
          end
        end
      end
      default: begin
        heading_nxt = heading_r;
      end
    endcase
  end

  // Result slot: fill on advance, empty when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Update state once per processed word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r   <= HEAD_STOP;
      weight_r    <= '0;
      hold_cnt_r  <= RST_HOLD_COUNT;
      turn_cnt_r  <= '0;
      ltgt_r      <= '0;
      rtgt_r      <= '0;
      lapp_r      <= '0;
      rapp_r      <= '0;
      rev_r       <= REV_NONE;
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        heading_r  <= heading_nxt;
        weight_r   <= weight_nxt;
        hold_cnt_r <= hold_cnt_nxt;
        turn_cnt_r <= turn_cnt_nxt;
        ltgt_r     <= ltgt_nxt;
        rtgt_r     <= rtgt_nxt;
        lapp_r     <= lapp_nxt;
        rapp_r     <= rapp_nxt;
        rev_r      <= rev_nxt;
        out_done_r <= done_nxt;
      end
    end
  end

  // The result word is the state just written plus the done flag
  assign out_chan.valid       = out_valid_r;
  assign out_chan.left_width  = lapp_r;
  assign out_chan.right_width = rapp_r;
  assign out_chan.left_back   = rev_r[0];
  assign out_chan.right_back  = rev_r[1];
  assign out_chan.move_done   = out_done_r;
  assign out_chan.heading     = heading_r;

endmodule

[rtl/line_follow_drive_controller.sv]
// ----------------------------------------------------------------------------
// line_follow_drive_controller
// Two-wheel line-follower drive: commands, line samples, control and turn ticks.
// ----------------------------------------------------------------------------
// Each event word returns exactly one result word. An event is captured in an
// input register and handled in a single pass by the core, which updates the
// drive state and loads the result register in the same cycle, so one word is
// accepted every clock; each word passes the input register and then the
// result register. Back pressure on the result side stalls the input register,
// which still takes one more word while a finished result waits. Configuration
// writes take effect at the next clock and must be made while idle.
module line_follow_drive_controller import lfdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  lfdc_in_if.sink               in_chan,
  lfdc_out_if.source            out_chan
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  advance;

  // Configuration registers
  lfdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Capture event words
  lfdc_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Process and hold the result
  lfdc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .out_chan   (out_chan)
  );

endmodule

[rtl/lfdc_checker.sv]
// ----------------------------------------------------------------------------
// lfdc_checker
// Port-level checks of the drive controller, bound to the top level.
// ----------------------------------------------------------------------------
module lfdc_checker import lfdc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  lfdc_in_if.sink    in_chan,
  lfdc_out_if.source out_chan
);

  // No result word right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  // With no result word waiting the input is always open
  a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_chan.valid |-> in_chan.ready)
    else $error("input stalled with an empty result slot");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.ready |=>
      out_chan.valid && $stable(out_chan.left_width) && $stable(out_chan.right_width) &&
      $stable(out_chan.heading) && $stable(out_chan.move_done))
    else $error("stalled result word changed");

  // A completed move always leaves the drive stopped
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.move_done |-> out_chan.heading == HEAD_STOP)
    else $error("move done without stop heading");

  // While stopped no wheel is driven
  a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.heading == HEAD_STOP |->
      out_chan.left_width == '0 && out_chan.right_width == '0)
    else $error("nonzero width while stopped");

endmodule

bind line_follow_drive_controller lfdc_checker u_lfdc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_chan  (in_chan),
  .out_chan (out_chan)
);
